// ===== hw/rtl/lisp_token_scanner_core_defines.svh =====
// assertion macros shared by the token scanner modules
`ifndef LISP_TOKEN_SCANNER_CORE_DEFINES_SVH
`define LISP_TOKEN_SCANNER_CORE_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define LTS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LTS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/lts_pkg.sv =====
// types, constants and helper functions of the lisp token scanner
package lts_pkg;

   localparam int unsigned LTS_POS_BITS = 24;
   localparam int unsigned LTS_QUEUE_DEPTH = 4;
   localparam int unsigned LTS_QUEUE_PTR_BITS = $clog2(LTS_QUEUE_DEPTH);
   localparam int unsigned LTS_QUEUE_CNT_BITS = $clog2(LTS_QUEUE_DEPTH + 1);

   typedef logic [LTS_POS_BITS-1:0] pos_word_type;

   typedef struct packed {
      pos_word_type offset;
      pos_word_type line;
      pos_word_type column;
   } pos_type;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_COMMENT = 3'd1,
      MODE_NUMBER  = 3'd2,
      MODE_IDENT   = 3'd3,
      MODE_STRING  = 3'd4,
      MODE_STR_ESC = 3'd5,
      MODE_TILDE   = 3'd6
   } scan_mode_type;

   typedef enum logic [4:0] {
      KIND_LPAREN    = 5'd0,
      KIND_LBRACKET  = 5'd1,
      KIND_LCURLY    = 5'd2,
      KIND_QUOTE     = 5'd3,
      KIND_BACKQUOTE = 5'd4,
      KIND_TILDE     = 5'd5,
      KIND_TILDE_AT  = 5'd6,
      KIND_CARET     = 5'd7,
      KIND_RPAREN    = 5'd8,
      KIND_RBRACKET  = 5'd9,
      KIND_RCURLY    = 5'd10,
      KIND_IDENT     = 5'd11,
      KIND_STRING    = 5'd12,
      KIND_NUMBER    = 5'd13,
      KIND_UNCLOSED  = 5'd14,
      KIND_END       = 5'd15
   } token_kind_type;

   localparam logic [7:0] CHAR_LF        = 8'd10;
   localparam logic [7:0] CHAR_CR        = 8'd13;
   localparam logic [7:0] CHAR_SPACE     = 8'd32;
   localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
   localparam logic [7:0] CHAR_LPAREN    = 8'h28;
   localparam logic [7:0] CHAR_RPAREN    = 8'h29;
   localparam logic [7:0] CHAR_COMMA     = 8'h2C;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_NINE      = 8'h39;
   localparam logic [7:0] CHAR_SEMI      = 8'h3B;
   localparam logic [7:0] CHAR_AT        = 8'h40;
   localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
   localparam logic [7:0] CHAR_BSLASH    = 8'h5C;
   localparam logic [7:0] CHAR_RBRACKET  = 8'h5D;
   localparam logic [7:0] CHAR_CARET     = 8'h5E;
   localparam logic [7:0] CHAR_BACKQUOTE = 8'h60;
   localparam logic [7:0] CHAR_LCURLY    = 8'h7B;
   localparam logic [7:0] CHAR_RCURLY    = 8'h7D;
   localparam logic [7:0] CHAR_TILDE     = 8'h7E;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [4:0]   token_kind;
      pos_word_type start_offset;
      pos_word_type start_line;
      pos_word_type start_column;
      pos_word_type end_offset;
      pos_word_type end_line;
      pos_word_type end_column;
      logic         last_of_run;
   } rsp_type;

   // tokens produced by one accepted item, packed to the front
   typedef struct packed {
      logic [1:0] count;
      rsp_type    tok0;
      rsp_type    tok1;
   } push_type;

   function automatic pos_word_type sat_inc(input pos_word_type v);
      sat_inc = (v == '1) ? v : v + pos_word_type'(1);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
   endfunction

   function automatic logic ident_continues(input logic [7:0] b);
      logic cont;
      cont = (b > CHAR_SPACE);
      case (b)
         CHAR_LBRACKET, CHAR_RBRACKET, CHAR_LCURLY, CHAR_RCURLY,
         CHAR_LPAREN, CHAR_RPAREN, CHAR_DQUOTE, CHAR_BACKQUOTE,
         CHAR_COMMA: cont = 1'b0;
         default: ;
      endcase
      ident_continues = cont;
   endfunction

   function automatic rsp_type make_token(input token_kind_type kind,
                                          input pos_type s, input pos_type e);
      rsp_type t;
      t.token_kind   = kind;
      t.start_offset = s.offset;
      t.start_line   = s.line;
      t.start_column = s.column;
      t.end_offset   = e.offset;
      t.end_line     = e.line;
      t.end_column   = e.column;
      t.last_of_run  = 1'b0;
      make_token = t;
   endfunction

endpackage

// ===== hw/rtl/lisp_token_scanner_core.sv =====
// top level of the lisp token scanner
// Streaming s-expression tokenizer. The req_ channel carries one source byte
// per transfer, or an end mark (end_of_text set, byte ignored). The rsp_
// channel carries tokens with kind, start and end offset, line and column,
// and last_of_run set on the final token caused by one request.
// A request gives zero, one or two tokens; the end mark always gives the
// end-of-stream token, preceded by any pending token.
// Tokens of a request are registered into the token queue as the request is
// taken and offered from the cycle after. Throughput: one request per cycle
// while each request gives at most one token and rsp_stall is low; a request
// giving two tokens leaves an extra one queued. The rate is set by the
// four-entry token queue, raising req_stall while more than two tokens wait.
// Reset (synchronous, active high) empties the queue, returns the scan to
// idle and sets the position to offset 0, line 1, column 1.
// While rsp_stall is high the front token holds; once the queue is near full
// req_stall rises until the receiver drains it.
module lisp_token_scanner_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lts_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lts_pkg::rsp_type rsp_data
);

   lts_pkg::push_type push;
   logic              accept;
   logic              full;

   assign req_stall = full;
   assign accept    = req_valid && !req_stall;

   lts_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .item   (req_data),
      .push   (push)
   );

   lts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hw/rtl/lts_scan.sv =====
// scanner state, position counters and token decode for one byte per cycle while accept is high
`include "lisp_token_scanner_core_defines.svh"

module lts_scan (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  lts_pkg::req_type  item,
   output lts_pkg::push_type push
);

   lts_pkg::scan_mode_type mode_ff, mode_in;
   lts_pkg::pos_type       cur_ff, start_ff, start_in, prev_ff;
   logic [7:0]             b;
   logic                   at_end;
   logic                   digit;
   logic                   ident_cont;
   logic                   resume_idle;
   logic                   a_valid, b_valid;
   lts_pkg::rsp_type       tok_a, tok_b;
   lts_pkg::push_type      push_v;

   assign b          = item.text_byte;
   assign at_end     = item.end_of_text;
   assign digit      = lts_pkg::is_digit(b);
   assign ident_cont = lts_pkg::ident_continues(b);

   // byte is scanned as if between tokens
   always_comb begin
      case (mode_ff)
         lts_pkg::MODE_COMMENT,
         lts_pkg::MODE_STRING,
         lts_pkg::MODE_STR_ESC: resume_idle = 1'b0;
         lts_pkg::MODE_NUMBER:  resume_idle = !digit;
         lts_pkg::MODE_IDENT:   resume_idle = !ident_cont;
         lts_pkg::MODE_TILDE:   resume_idle = (b != lts_pkg::CHAR_AT);
         default:               resume_idle = 1'b1;
      endcase
   end

   // next state
   always_comb begin
      mode_in  = mode_ff;
      start_in = start_ff;
      if (accept) begin
         if (at_end) begin
            mode_in = lts_pkg::MODE_IDLE;
         end else begin
            case (mode_ff)
               lts_pkg::MODE_COMMENT: begin
                  if (b == lts_pkg::CHAR_CR || b == lts_pkg::CHAR_LF)
                     mode_in = lts_pkg::MODE_IDLE;
               end
               lts_pkg::MODE_STRING: begin
                  if (b == lts_pkg::CHAR_BSLASH)
                     mode_in = lts_pkg::MODE_STR_ESC;
                  else if (b == lts_pkg::CHAR_DQUOTE)
                     mode_in = lts_pkg::MODE_IDLE;
               end
               lts_pkg::MODE_STR_ESC: mode_in = lts_pkg::MODE_STRING;
               lts_pkg::MODE_TILDE:   mode_in = lts_pkg::MODE_IDLE;
               default: ;
            endcase
            if (resume_idle) begin
               mode_in = lts_pkg::MODE_IDLE;
               if (b > lts_pkg::CHAR_SPACE) begin
                  case (b)
                     lts_pkg::CHAR_SEMI: mode_in = lts_pkg::MODE_COMMENT;
                     lts_pkg::CHAR_LPAREN, lts_pkg::CHAR_RPAREN,
                     lts_pkg::CHAR_LBRACKET, lts_pkg::CHAR_RBRACKET,
                     lts_pkg::CHAR_LCURLY, lts_pkg::CHAR_RCURLY,
                     lts_pkg::CHAR_SQUOTE, lts_pkg::CHAR_BACKQUOTE,
                     lts_pkg::CHAR_CARET: ;
                     lts_pkg::CHAR_TILDE: begin
                        mode_in  = lts_pkg::MODE_TILDE;
                        start_in = cur_ff;
                     end
                     lts_pkg::CHAR_DQUOTE: begin
                        mode_in  = lts_pkg::MODE_STRING;
                        start_in = cur_ff;
                     end
                     default: begin
                        mode_in  = digit ? lts_pkg::MODE_NUMBER : lts_pkg::MODE_IDENT;
                        start_in = cur_ff;
                     end
                  endcase
               end
            end
         end
      end
   end

   // outputs: a is the token closed by this byte, b the single-character token it forms or the end mark
   always_comb begin
      a_valid = 1'b0;
      b_valid = 1'b0;
      tok_a   = lts_pkg::make_token(lts_pkg::KIND_NUMBER, start_ff, prev_ff);
      tok_b   = lts_pkg::make_token(lts_pkg::KIND_END, cur_ff, cur_ff);
      if (accept) begin
         if (at_end) begin
            b_valid = 1'b1;
            case (mode_ff)
               lts_pkg::MODE_NUMBER: a_valid = 1'b1;
               lts_pkg::MODE_IDENT: begin
                  a_valid = 1'b1;
                  tok_a   = lts_pkg::make_token(lts_pkg::KIND_IDENT, start_ff, prev_ff);
               end
               lts_pkg::MODE_TILDE: begin
                  a_valid = 1'b1;
                  tok_a   = lts_pkg::make_token(lts_pkg::KIND_TILDE, start_ff, start_ff);
               end
               lts_pkg::MODE_STRING, lts_pkg::MODE_STR_ESC: begin
                  a_valid = 1'b1;
                  tok_a   = lts_pkg::make_token(lts_pkg::KIND_UNCLOSED, start_ff, prev_ff);
               end
               default: ;
            endcase
         end else begin
            case (mode_ff)
               lts_pkg::MODE_NUMBER: a_valid = !digit;
               lts_pkg::MODE_IDENT: begin
                  a_valid = !ident_cont;
                  tok_a   = lts_pkg::make_token(lts_pkg::KIND_IDENT, start_ff, prev_ff);
               end
               lts_pkg::MODE_TILDE: begin
                  a_valid = 1'b1;
                  if (b == lts_pkg::CHAR_AT)
                     tok_a = lts_pkg::make_token(lts_pkg::KIND_TILDE_AT, start_ff, cur_ff);
                  else
                     tok_a = lts_pkg::make_token(lts_pkg::KIND_TILDE, start_ff, start_ff);
               end
               lts_pkg::MODE_STRING: begin
                  a_valid = (b == lts_pkg::CHAR_DQUOTE);
                  tok_a   = lts_pkg::make_token(lts_pkg::KIND_STRING, start_ff, cur_ff);
               end
               default: ;
            endcase
            if (resume_idle) begin
               case (b)
                  lts_pkg::CHAR_LPAREN: begin
                     b_valid = 1'b1;
                     tok_b   = lts_pkg::make_token(lts_pkg::KIND_LPAREN, cur_ff, cur_ff);
                  end
                  lts_pkg::CHAR_RPAREN: begin
                     b_valid = 1'b1;
                     tok_b   = lts_pkg::make_token(lts_pkg::KIND_RPAREN, cur_ff, cur_ff);
                  end
                  lts_pkg::CHAR_LBRACKET: begin
                     b_valid = 1'b1;
                     tok_b   = lts_pkg::make_token(lts_pkg::KIND_LBRACKET, cur_ff, cur_ff);
                  end
                  lts_pkg::CHAR_RBRACKET: begin
                     b_valid = 1'b1;
                     tok_b   = lts_pkg::make_token(lts_pkg::KIND_RBRACKET, cur_ff, cur_ff);
                  end
                  lts_pkg::CHAR_LCURLY: begin
                     b_valid = 1'b1;
                     tok_b   = lts_pkg::make_token(lts_pkg::KIND_LCURLY, cur_ff, cur_ff);
                  end
                  lts_pkg::CHAR_RCURLY: begin
                     b_valid = 1'b1;
                     tok_b   = lts_pkg::make_token(lts_pkg::KIND_RCURLY, cur_ff, cur_ff);
                  end
                  lts_pkg::CHAR_SQUOTE: begin
                     b_valid = 1'b1;
                     tok_b   = lts_pkg::make_token(lts_pkg::KIND_QUOTE, cur_ff, cur_ff);
                  end
                  lts_pkg::CHAR_BACKQUOTE: begin
                     b_valid = 1'b1;
                     tok_b   = lts_pkg::make_token(lts_pkg::KIND_BACKQUOTE, cur_ff, cur_ff);
                  end
                  lts_pkg::CHAR_CARET: begin
                     b_valid = 1'b1;
                     tok_b   = lts_pkg::make_token(lts_pkg::KIND_CARET, cur_ff, cur_ff);
                  end
                  default: ;
               endcase
            end
         end
      end
   end

   always_comb begin
      push_v.count = {1'b0, a_valid} + {1'b0, b_valid};
      push_v.tok0  = a_valid ? tok_a : tok_b;
      push_v.tok1  = tok_b;
      if (a_valid && b_valid)
         push_v.tok1.last_of_run = 1'b1;
      else
         push_v.tok0.last_of_run = 1'b1;
   end

   assign push = push_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= lts_pkg::MODE_IDLE;
         cur_ff.offset   <= '0;
         cur_ff.line     <= lts_pkg::pos_word_type'(1);
         cur_ff.column   <= lts_pkg::pos_word_type'(1);
         start_ff.offset <= '0;
         start_ff.line   <= lts_pkg::pos_word_type'(1);
         start_ff.column <= lts_pkg::pos_word_type'(1);
         prev_ff.offset  <= '0;
         prev_ff.line    <= lts_pkg::pos_word_type'(1);
         prev_ff.column  <= lts_pkg::pos_word_type'(1);
      end else begin
         mode_ff  <= mode_in;
         start_ff <= start_in;
         if (accept && !at_end) begin
            prev_ff       <= cur_ff;
            cur_ff.offset <= lts_pkg::sat_inc(cur_ff.offset);
            if (b == lts_pkg::CHAR_LF) begin
               cur_ff.line   <= lts_pkg::sat_inc(cur_ff.line);
               cur_ff.column <= lts_pkg::pos_word_type'(1);
            end else begin
               cur_ff.column <= lts_pkg::sat_inc(cur_ff.column);
            end
         end
      end
   end

   `LTS_ASSERT_NOW(end_gives_end_token, accept && at_end,
      push_v.count != 2'd0 && ((push_v.count == 2'd1 &&
      push_v.tok0.token_kind == lts_pkg::KIND_END) || (push_v.count == 2'd2 &&
      push_v.tok1.token_kind == lts_pkg::KIND_END)), "end mark without end token")
   `LTS_ASSERT_NEXT(end_returns_idle, accept && at_end,
      mode_ff == lts_pkg::MODE_IDLE, "scan not idle after end mark")

endmodule

// ===== hw/rtl/lts_queue.sv =====
// result queue taking up to two tokens per cycle and giving one per transfer
`include "lisp_token_scanner_core_defines.svh"

module lts_queue (
   input  logic              clock,
   input  logic              reset,
   input  lts_pkg::push_type push,
   output logic              full,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lts_pkg::rsp_type  rsp_data
);

   localparam int unsigned PtrBits = lts_pkg::LTS_QUEUE_PTR_BITS;
   localparam int unsigned CntBits = lts_pkg::LTS_QUEUE_CNT_BITS;

   lts_pkg::rsp_type     entry_ff [lts_pkg::LTS_QUEUE_DEPTH];
   logic [PtrBits-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CntBits-1:0]   count_ff, count_in;
   logic                 pop;

   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   // room for two tokens is needed before an item is taken
   assign full      = (count_ff > CntBits'(lts_pkg::LTS_QUEUE_DEPTH - 2));

   assign count_in = count_ff + CntBits'(push.count) - CntBits'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0)
         entry_ff[wr_ptr_ff] <= push.tok0;
      if (push.count == 2'd2)
         entry_ff[wr_ptr_ff + PtrBits'(1)] <= push.tok1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PtrBits'(push.count);
         rd_ptr_ff <= rd_ptr_ff + PtrBits'(pop);
         count_ff  <= count_in;
      end
   end

   `LTS_ASSERT_NOW(queue_no_overflow, push.count != 2'd0,
      count_ff <= CntBits'(lts_pkg::LTS_QUEUE_DEPTH - 2), "token pushed into full queue")
   `LTS_ASSERT_NOW(queue_bounded, 1'b1,
      count_ff <= CntBits'(lts_pkg::LTS_QUEUE_DEPTH), "queue count beyond depth")
   `LTS_ASSERT_NEXT(queue_pop_only, pop && push.count == 2'd0,
      count_ff == $past(count_ff) - CntBits'(1), "queue count wrong after transfer out")

endmodule
